// File: rtl/assert_macros.svh
// Assertion macros for the RTL files, included by the splitter top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define LPNS_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("lpns assertion failed");

// Check that a condition implies another at the same clock edge.
`define LPNS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpns implication failed");

`else

`define LPNS_ASSERT(label, clk, rst, cond)
`define LPNS_ASSERT_IMPLY(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/lpns_pkg.sv
`default_nettype none

package lpns_pkg;

   localparam int SAMPLE_LENGTH_BITS = 24;
   localparam int QUEUE_DEPTH        = 2;
   localparam int BYTE_BITS          = 8;
   localparam int ACC_BITS           = 32;
   localparam int UNIT_LENGTH_BITS   = 24;
   localparam int LFS_BITS           = 3;

   localparam logic [LFS_BITS-1:0] LFS_RESET = 3'd4;
   localparam logic [LFS_BITS-1:0] LFS_MAX   = 3'd4;

   localparam logic [UNIT_LENGTH_BITS-1:0] UNIT_LENGTH_SAT = {UNIT_LENGTH_BITS{1'b1}};

   typedef enum logic [1:0] {
      STATUS_PAYLOAD   = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_OVERRUN   = 2'd2,
      STATUS_CUT_SHORT = 2'd3
   } status_type;

   // One queued result word, handed from the front to the back.
   typedef struct packed {
      status_type           status;
      logic [BYTE_BITS-1:0] data;
      logic                 unit_first;
      logic                 unit_last;
      logic                 sample_first_unit;
      logic                 sample_last_unit;
      logic [ACC_BITS-1:0]  unit_length;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/length_prefixed_nal_unit_splitter.sv
`default_nettype none
`include "assert_macros.svh"

// Splits a sample, fed one byte per word with its length on the first byte, into length-prefixed
// units and emits each payload byte with unit and sample marks, one empty-unit word per unit of
// length zero, and one error word when a declared length overruns the sample or a prefix is cut
// short (the rest of that sample is then dropped). The block takes one byte every cycle while
// the queue has room: the front parser updates all its counters at the edge that takes a byte.
// Each result is written into a two-entry queue at that same edge and then moved into the output
// register once the output register is empty or being drained. The queue lets the front keep
// taking bytes while a result waits; req_ready falls only once the queue is full.
// length_field_size (address 0, reset 4, values above 4 act as 4) is read at each unit
// boundary, and should be written only while the block is idle.
module length_prefixed_nal_unit_splitter #(
   parameter int QUEUE_DEPTH = lpns_pkg::QUEUE_DEPTH
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic [lpns_pkg::BYTE_BITS-1:0]          req_data_byte,
   input  wire logic                                    req_sample_first,
   input  wire logic [lpns_pkg::SAMPLE_LENGTH_BITS-1:0] req_sample_length,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic [1:0]                                   rsp_status,
   output logic [lpns_pkg::BYTE_BITS-1:0]               rsp_payload_byte,
   output logic                                         rsp_unit_first,
   output logic                                         rsp_unit_last,
   output logic                                         rsp_sample_first_unit,
   output logic                                         rsp_sample_last_unit,
   output logic [lpns_pkg::UNIT_LENGTH_BITS-1:0]        rsp_unit_length,
   input  wire logic                                    psel,
   input  wire logic                                    penable,
   input  wire logic                                    pwrite,
   input  wire logic [1:0]                              paddr,
   input  wire logic [31:0]                             pwdata,
   output logic [31:0]                                  prdata,
   output logic                                         pready
);

   localparam int LB = lpns_pkg::LFS_BITS;

   logic [LB-1:0]        lfs_ff, lfs_in;
   logic                 cfg_write;
   logic                 queue_full, push, pop_valid, pop;
   lpns_pkg::result_type push_word, pop_word;

   // Register port: one register, always ready.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign lfs_in    = cfg_write ? pwdata[LB-1:0] : lfs_ff;
   assign prdata    = {{(32 - LB){1'b0}}, lfs_ff} | {30'b0, paddr & 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         lfs_ff <= lpns_pkg::LFS_RESET;
      end else begin
         lfs_ff <= lfs_in;
      end
   end

   lpns_front u_front (
      .clock             (clock),
      .reset             (reset),
      .length_field_size (lfs_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_sample_first  (req_sample_first),
      .req_sample_length (req_sample_length),
      .queue_full        (queue_full),
      .push              (push),
      .push_word         (push_word)
   );

   lpns_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_word  (pop_word)
   );

   lpns_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .pop_valid             (pop_valid),
      .pop                   (pop),
      .pop_word              (pop_word),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_payload_byte      (rsp_payload_byte),
      .rsp_unit_first        (rsp_unit_first),
      .rsp_unit_last         (rsp_unit_last),
      .rsp_sample_first_unit (rsp_sample_first_unit),
      .rsp_sample_last_unit  (rsp_sample_last_unit),
      .rsp_unit_length       (rsp_unit_length)
   );

   // Error words carry no unit marks and never close the sample.
   `LPNS_ASSERT_IMPLY(a_error_marks, clock, reset,
      rsp_valid && (rsp_status == lpns_pkg::STATUS_OVERRUN ||
      rsp_status == lpns_pkg::STATUS_CUT_SHORT),
      !rsp_unit_first && !rsp_unit_last && !rsp_sample_last_unit && rsp_payload_byte == '0)
   // An empty unit is both first and last and has zero length.
   `LPNS_ASSERT_IMPLY(a_empty_unit, clock, reset,
      rsp_valid && rsp_status == lpns_pkg::STATUS_EMPTY,
      rsp_unit_first && rsp_unit_last && rsp_unit_length == '0 && rsp_payload_byte == '0)
   // A payload byte always belongs to a unit of nonzero length.
   `LPNS_ASSERT_IMPLY(a_payload_length, clock, reset,
      rsp_valid && rsp_status == lpns_pkg::STATUS_PAYLOAD, rsp_unit_length != '0)
   // A word is pushed only while the queue has room.
   `LPNS_ASSERT(a_no_overflow, clock, reset, !(push && queue_full))

endmodule

`default_nettype wire

// File: rtl/lpns_front.sv
`default_nettype none

module lpns_front (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic [lpns_pkg::LFS_BITS-1:0]           length_field_size,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic [lpns_pkg::BYTE_BITS-1:0]          req_data_byte,
   input  wire logic                                    req_sample_first,
   input  wire logic [lpns_pkg::SAMPLE_LENGTH_BITS-1:0] req_sample_length,
   input  wire logic                                    queue_full,
   output logic                                         push,
   output lpns_pkg::result_type                         push_word
);

   localparam int SLB = lpns_pkg::SAMPLE_LENGTH_BITS;
   localparam int AB  = lpns_pkg::ACC_BITS;
   localparam int BB  = lpns_pkg::BYTE_BITS;
   localparam int LB  = lpns_pkg::LFS_BITS;

   logic [SLB-1:0] sample_left_ff, sample_left_in;
   logic [LB-1:0]  prefix_left_ff, prefix_left_in;
   logic [AB-1:0]  acc_ff, acc_in;
   logic [SLB-1:0] unit_left_ff, unit_left_in;
   logic           first_unit_ff, first_unit_in;
   logic           discard_ff, discard_in;
   logic           last_unit_ff, last_unit_in;

   logic           accept;
   logic [SLB-1:0] rem;
   logic [LB-1:0]  lfs;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign lfs       = (length_field_size > lpns_pkg::LFS_MAX) ?
                      lpns_pkg::LFS_MAX : length_field_size;

   // Classify the accepted word and work out the next parser state.
   always_comb begin
      sample_left_in = sample_left_ff;
      prefix_left_in = prefix_left_ff;
      acc_in         = acc_ff;
      unit_left_in   = unit_left_ff;
      first_unit_in  = first_unit_ff;
      discard_in     = discard_ff;
      last_unit_in   = last_unit_ff;
      rem            = '0;
      push           = 1'b0;
      push_word      = '0;
      push_word.data = req_data_byte;
      if (accept) begin
         // Restart on the first byte of a sample.
         if (req_sample_first) begin
            sample_left_in = SLB'(req_sample_length);
            prefix_left_in = '0;
            acc_in         = '0;
            unit_left_in   = '0;
            first_unit_in  = 1'b1;
            discard_in     = 1'b0;
            last_unit_in   = 1'b0;
         end
         if (sample_left_in != '0) begin
            if (discard_in) begin
               // Drop the rest of a broken sample.
               sample_left_in = sample_left_in - 1'b1;
            end else begin
               // Open a new unit at a boundary.
               if (unit_left_in == '0 && prefix_left_in == '0) begin
                  if (lfs == '0) begin
                     unit_left_in = sample_left_in;
                     acc_in       = AB'(sample_left_in);
                     last_unit_in = 1'b1;
                  end else begin
                     prefix_left_in = lfs;
                     acc_in         = '0;
                  end
               end
               sample_left_in = sample_left_in - 1'b1;
               rem            = sample_left_in;
               if (unit_left_in != '0) begin
                  // Pass a payload byte.
                  push                        = 1'b1;
                  push_word.status            = lpns_pkg::STATUS_PAYLOAD;
                  push_word.unit_first        = (AB'(unit_left_in) == acc_in);
                  push_word.unit_last         = (unit_left_in == SLB'(1));
                  push_word.sample_first_unit = first_unit_in;
                  push_word.sample_last_unit  = last_unit_in;
                  push_word.unit_length       = acc_in;
                  unit_left_in                = unit_left_in - 1'b1;
                  if (unit_left_in == '0) begin
                     first_unit_in = 1'b0;
                  end
               end else begin
                  // Gather a prefix byte, most significant first.
                  acc_in         = {acc_in[AB-BB-1:0], req_data_byte};
                  prefix_left_in = prefix_left_in - 1'b1;
                  if (prefix_left_in == '0) begin
                     if (acc_in > AB'(rem)) begin
                        push                        = 1'b1;
                        push_word.status            = lpns_pkg::STATUS_OVERRUN;
                        push_word.sample_first_unit = first_unit_in;
                        push_word.unit_length       = acc_in;
                        discard_in                  = 1'b1;
                     end else if (acc_in == '0) begin
                        push                        = 1'b1;
                        push_word.status            = lpns_pkg::STATUS_EMPTY;
                        push_word.unit_first        = 1'b1;
                        push_word.unit_last         = 1'b1;
                        push_word.sample_first_unit = first_unit_in;
                        push_word.sample_last_unit  = (rem == '0);
                        first_unit_in               = 1'b0;
                     end else begin
                        unit_left_in = SLB'(acc_in);
                        last_unit_in = (acc_in == AB'(rem));
                     end
                  end else if (rem == '0) begin
                     push                        = 1'b1;
                     push_word.status            = lpns_pkg::STATUS_CUT_SHORT;
                     push_word.sample_first_unit = first_unit_in;
                     prefix_left_in              = '0;
                     discard_in                  = 1'b1;
                  end
               end
            end
         end
      end
   end

   // Hold the parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_left_ff <= '0;
         prefix_left_ff <= '0;
         acc_ff         <= '0;
         unit_left_ff   <= '0;
         first_unit_ff  <= 1'b1;
         discard_ff     <= 1'b0;
         last_unit_ff   <= 1'b0;
      end else begin
         sample_left_ff <= sample_left_in;
         prefix_left_ff <= prefix_left_in;
         acc_ff         <= acc_in;
         unit_left_ff   <= unit_left_in;
         first_unit_ff  <= first_unit_in;
         discard_ff     <= discard_in;
         last_unit_ff   <= last_unit_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lpns_queue.sv
`default_nettype none

module lpns_queue #(
   parameter int QUEUE_DEPTH = lpns_pkg::QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lpns_pkg::result_type push_word,
   output logic                      full,
   output logic                      pop_valid,
   input  wire logic                 pop,
   output lpns_pkg::result_type      pop_word
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);

   lpns_pkg::result_type slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_word  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Advance the pointers and the fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lpns_back.sv
`default_nettype none

module lpns_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  pop_valid,
   output logic                                       pop,
   input  wire lpns_pkg::result_type                  pop_word,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [1:0]                                 rsp_status,
   output logic [lpns_pkg::BYTE_BITS-1:0]             rsp_payload_byte,
   output logic                                       rsp_unit_first,
   output logic                                       rsp_unit_last,
   output logic                                       rsp_sample_first_unit,
   output logic                                       rsp_sample_last_unit,
   output logic [lpns_pkg::UNIT_LENGTH_BITS-1:0]      rsp_unit_length
);

   localparam int AB = lpns_pkg::ACC_BITS;
   localparam int UB = lpns_pkg::UNIT_LENGTH_BITS;

   logic                          valid_ff, valid_in;
   logic [1:0]                    status_ff;
   logic [lpns_pkg::BYTE_BITS-1:0] byte_ff, byte_in;
   logic                          ufirst_ff, ulast_ff, sfirst_ff, slast_ff;
   logic [UB-1:0]                 ulen_ff, ulen_in;

   // Take a new word when the output register is empty or being drained.
   assign pop = pop_valid && (!valid_ff || rsp_ready);

   // Format the word: clear the byte off payload, saturate the length.
   always_comb begin
      byte_in = (pop_word.status == lpns_pkg::STATUS_PAYLOAD) ? pop_word.data : '0;
      ulen_in = (pop_word.unit_length > AB'(lpns_pkg::UNIT_LENGTH_SAT)) ?
                lpns_pkg::UNIT_LENGTH_SAT : pop_word.unit_length[UB-1:0];
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the output payload.
   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= pop_word.status;
         byte_ff   <= byte_in;
         ufirst_ff <= pop_word.unit_first;
         ulast_ff  <= pop_word.unit_last;
         sfirst_ff <= pop_word.sample_first_unit;
         slast_ff  <= pop_word.sample_last_unit;
         ulen_ff   <= ulen_in;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_payload_byte      = byte_ff;
   assign rsp_unit_first        = ufirst_ff;
   assign rsp_unit_last         = ulast_ff;
   assign rsp_sample_first_unit = sfirst_ff;
   assign rsp_sample_last_unit  = slast_ff;
   assign rsp_unit_length       = ulen_ff;

endmodule

`default_nettype wire
